[hw/rtl/rcs_pkg.sv]
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared widths, constants and stage payload types for the column setup pipe.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int COLUMNS   = 640;
  localparam int FRAC_BITS = 16;

  localparam int COL_W  = 10;
  localparam int POS_W  = 24;
  localparam int DIR_W  = 18;
  localparam int RAY_W  = 19;
  localparam int MAG_W  = 19;
  localparam int DIST_W = 32;
  localparam int CELL_W = 8;
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 3;

  // camera coordinate spans -1.0 .. +1.0
  localparam int CAM_W = FRAC_BITS + 2;

  // reciprocal of 1 << 2F gives 2F+1 quotient bits
  localparam int DIV_STEPS = 2 * FRAC_BITS + 1;
  localparam int QUO_W     = DIV_STEPS;

  // register indexes
  localparam logic [IDX_W-1:0] REG_POS_X   = 3'd0;
  localparam logic [IDX_W-1:0] REG_POS_Y   = 3'd1;
  localparam logic [IDX_W-1:0] REG_DIR_X   = 3'd2;
  localparam logic [IDX_W-1:0] REG_DIR_Y   = 3'd3;
  localparam logic [IDX_W-1:0] REG_PLANE_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_PLANE_Y = 3'd5;

  typedef struct packed {
    logic                    vld;
    logic signed [CAM_W-1:0] cam;
  } cam_t;

  typedef struct packed {
    logic                    vld;
    logic signed [RAY_W-1:0] rx;
    logic signed [RAY_W-1:0] ry;
  } ray_t;

  typedef struct packed {
    logic                    vld;
    logic signed [RAY_W-1:0] rx;
    logic signed [RAY_W-1:0] ry;
    logic [QUO_W-1:0]        qx;
    logic [QUO_W-1:0]        qy;
  } recip_t;

endpackage

[hw/rtl/rcs_cam.sv]
// ----------------------------------------------------------------------------
// rcs_cam
// Camera coordinate 2x/(W-1) - 1 in four stages, constant divide by
// reciprocal multiply with a single correction step.
// ----------------------------------------------------------------------------
module rcs_cam (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic [rcs_pkg::COL_W-1:0] column,
  output rcs_pkg::cam_t             cam_out
);

  localparam int D_VAL = rcs_pkg::COLUMNS - 1;
  localparam int CW    = rcs_pkg::COL_W;
  localparam int P_W   = CW + rcs_pkg::FRAC_BITS + 2;
  localparam int T_W   = 2 * CW;
  localparam int PR_W  = T_W + 33;
  localparam logic [CW-1:0]  CAM_D     = CW'(D_VAL);
  localparam logic [P_W-1:0] CAM_Q     = P_W'((1 << (rcs_pkg::FRAC_BITS + 1)) / D_VAL);
  localparam logic [CW-1:0]  CAM_R     = CW'((1 << (rcs_pkg::FRAC_BITS + 1)) % D_VAL);
  localparam logic [32:0]    CAM_RECIP = 33'((64'd1 << 32) / D_VAL);
  localparam logic signed [rcs_pkg::CAM_W-1:0] ONE_FX =
    rcs_pkg::CAM_W'(1 << rcs_pkg::FRAC_BITS);

  logic            v0, v1, v2;
  logic [CW-1:0]   col0;
  logic [P_W-1:0]  p1, p2;
  logic [T_W-1:0]  t1, t2, q0;
  logic [PR_W-1:0] prod;
  logic [T_W-1:0]  rem;
  logic [T_W-1:0]  q_fix;
  logic [P_W-1:0]  sum;

  assign prod  = PR_W'(t1) * PR_W'(CAM_RECIP);
  assign rem   = t2 - T_W'(q0 * T_W'(CAM_D));
  assign q_fix = q0 + T_W'(rem >= T_W'(CAM_D));
  assign sum   = p2 + P_W'(q_fix);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      cam_out.vld <= 1'b0;
    end else begin
      v0 <= in_vld;
      v1 <= v0;
      v2 <= v1;
      cam_out.vld <= v2;
    end
    col0 <= (column > CAM_D) ? CAM_D : column;
    p1   <= P_W'(col0) * CAM_Q;
    t1   <= T_W'(col0) * T_W'(CAM_R);
    p2   <= p1;
    t2   <= t1;
    q0   <= prod[32 +: T_W];
    cam_out.cam <= $signed(rcs_pkg::CAM_W'(sum)) - ONE_FX;
  end

endmodule

[hw/rtl/rcs_ray.sv]
// ----------------------------------------------------------------------------
// rcs_ray
// Ray direction dir + floor(plane*cam >> F), saturated to 19 bits. Two stages.
// ----------------------------------------------------------------------------
module rcs_ray (
  input  logic                             clk,
  input  logic                             rst,
  input  rcs_pkg::cam_t                    cam_in,
  input  logic signed [rcs_pkg::DIR_W-1:0] dir_x,
  input  logic signed [rcs_pkg::DIR_W-1:0] dir_y,
  input  logic signed [rcs_pkg::DIR_W-1:0] plane_x,
  input  logic signed [rcs_pkg::DIR_W-1:0] plane_y,
  output rcs_pkg::ray_t                    ray_out
);

  localparam int PW = rcs_pkg::DIR_W + rcs_pkg::CAM_W;
  localparam int SW = PW - rcs_pkg::FRAC_BITS + 1;
  localparam logic signed [SW-1:0] RAY_MAX = SW'((1 << (rcs_pkg::RAY_W - 1)) - 1);
  localparam logic signed [SW-1:0] RAY_MIN = -SW'(1 << (rcs_pkg::RAY_W - 1));

  logic                 v1;
  logic signed [PW-1:0] px, py;
  logic signed [SW-1:0] sx, sy;

  function automatic logic signed [rcs_pkg::RAY_W-1:0] sat_ray(
    input logic signed [SW-1:0] v
  );
    if (v > RAY_MAX) return rcs_pkg::RAY_W'(RAY_MAX);
    if (v < RAY_MIN) return rcs_pkg::RAY_W'(RAY_MIN);
    return rcs_pkg::RAY_W'(v);
  endfunction

  // arithmetic shift is the floor
  assign sx = SW'(dir_x) + SW'(px >>> rcs_pkg::FRAC_BITS);
  assign sy = SW'(dir_y) + SW'(py >>> rcs_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      ray_out.vld <= 1'b0;
    end else begin
      v1 <= cam_in.vld;
      ray_out.vld <= v1;
    end
    px <= PW'(plane_x) * PW'(cam_in.cam);
    py <= PW'(plane_y) * PW'(cam_in.cam);
    ray_out.rx <= sat_ray(sx);
    ray_out.ry <= sat_ray(sy);
  end

endmodule

[hw/rtl/rcs_recip.sv]
// ----------------------------------------------------------------------------
// rcs_recip
// Pipelined restoring divide of 1 << 2F by |ray|, both axes, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module rcs_recip (
  input  logic            clk,
  input  logic            rst,
  input  rcs_pkg::ray_t   ray_in,
  output rcs_pkg::recip_t rcp_out
);

  localparam int N   = rcs_pkg::DIV_STEPS;
  localparam int MW  = rcs_pkg::MAG_W;
  localparam int RW  = rcs_pkg::RAY_W;
  localparam int QW  = rcs_pkg::QUO_W;

  logic                 vld   [N];
  logic signed [RW-1:0] rx    [N];
  logic signed [RW-1:0] ry    [N];
  logic [MW-1:0]        mx    [N];
  logic [MW-1:0]        my    [N];
  logic [MW-1:0]        remx  [N];
  logic [MW-1:0]        remy  [N];
  logic [QW-1:0]        qx    [N];
  logic [QW-1:0]        qy    [N];

  logic [MW-1:0]        in_mx, in_my;
  logic [MW:0]          trx   [N];
  logic [MW:0]          try_  [N];
  logic [MW-1:0]        srcmx [N];
  logic [MW-1:0]        srcmy [N];
  logic [QW-1:0]        srcqx [N];
  logic [QW-1:0]        srcqy [N];

  assign in_mx = ray_in.rx[RW-1] ? MW'(-ray_in.rx) : MW'(ray_in.rx);
  assign in_my = ray_in.ry[RW-1] ? MW'(-ray_in.ry) : MW'(ray_in.ry);

  // the dividend's single set bit enters at the first stage
  always_comb begin
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        srcmx[s] = in_mx;
        srcmy[s] = in_my;
        srcqx[s] = '0;
        srcqy[s] = '0;
        trx[s]   = (MW+1)'(1);
        try_[s]  = (MW+1)'(1);
      end else begin
        srcmx[s] = mx[s-1];
        srcmy[s] = my[s-1];
        srcqx[s] = qx[s-1];
        srcqy[s] = qy[s-1];
        trx[s]   = {remx[s-1], 1'b0};
        try_[s]  = {remy[s-1], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < N; s++) begin
      if (rst) vld[s] <= 1'b0;
      else     vld[s] <= (s == 0) ? ray_in.vld : vld[s-1];
      rx[s] <= (s == 0) ? ray_in.rx : rx[s-1];
      ry[s] <= (s == 0) ? ray_in.ry : ry[s-1];
      mx[s] <= srcmx[s];
      my[s] <= srcmy[s];
      if (trx[s] >= (MW+1)'(srcmx[s])) begin
        remx[s] <= MW'(trx[s] - (MW+1)'(srcmx[s]));
        qx[s]   <= {srcqx[s][QW-2:0], 1'b1};
      end else begin
        remx[s] <= MW'(trx[s]);
        qx[s]   <= {srcqx[s][QW-2:0], 1'b0};
      end
      if (try_[s] >= (MW+1)'(srcmy[s])) begin
        remy[s] <= MW'(try_[s] - (MW+1)'(srcmy[s]));
        qy[s]   <= {srcqy[s][QW-2:0], 1'b1};
      end else begin
        remy[s] <= MW'(try_[s]);
        qy[s]   <= {srcqy[s][QW-2:0], 1'b0};
      end
    end
  end

  assign rcp_out.vld = vld[N-1];
  assign rcp_out.rx  = rx[N-1];
  assign rcp_out.ry  = ry[N-1];
  assign rcp_out.qx  = qx[N-1];
  assign rcp_out.qy  = qy[N-1];

endmodule

[hw/rtl/rcs_side.sv]
// ----------------------------------------------------------------------------
// rcs_side
// Delta selection with the zero rules, side distance product and the
// registered result. Three stages.
// ----------------------------------------------------------------------------
module rcs_side (
  input  logic                              clk,
  input  logic                              rst,
  input  rcs_pkg::recip_t                   rcp_in,
  input  logic [rcs_pkg::POS_W-1:0]         pos_x,
  input  logic [rcs_pkg::POS_W-1:0]         pos_y,
  output logic                              done,
  output logic [rcs_pkg::CELL_W-1:0]        cell_x,
  output logic [rcs_pkg::CELL_W-1:0]        cell_y,
  output logic                              step_x_neg,
  output logic                              step_y_neg,
  output logic signed [rcs_pkg::RAY_W-1:0]  ray_x,
  output logic signed [rcs_pkg::RAY_W-1:0]  ray_y,
  output logic [rcs_pkg::DIST_W-1:0]        delta_x,
  output logic [rcs_pkg::DIST_W-1:0]        delta_y,
  output logic [rcs_pkg::DIST_W-1:0]        side_x,
  output logic [rcs_pkg::DIST_W-1:0]        side_y
);

  localparam int F  = rcs_pkg::FRAC_BITS;
  localparam int DW = rcs_pkg::DIST_W;
  localparam int FW = F + 1;
  localparam int PW = FW + DW;
  localparam int RW = rcs_pkg::RAY_W;
  localparam logic [DW-1:0] ONE_D = DW'(1 << F);
  localparam logic [FW-1:0] ONE_F = FW'(1 << F);

  function automatic logic [DW-1:0] pick_delta(
    input logic signed [RW-1:0]   own,
    input logic signed [RW-1:0]   other,
    input logic [rcs_pkg::QUO_W-1:0] q
  );
    if (other == '0) return '0;
    if (own == '0)   return ONE_D;
    if (q[rcs_pkg::QUO_W-1]) return '1;
    return q[DW-1:0];
  endfunction

  function automatic logic [FW-1:0] side_frac(
    input logic [rcs_pkg::POS_W-1:0] pos,
    input logic                      neg
  );
    logic [FW-1:0] fr;
    fr = FW'(pos[F-1:0]);
    return neg ? fr : ONE_F - fr;
  endfunction

  logic                 v1, v2;
  logic signed [RW-1:0] rx1, ry1, rx2, ry2;
  logic [DW-1:0]        dx1, dy1, dx2, dy2;
  logic [FW-1:0]        fx1, fy1;
  logic [PW-1:0]        px2, py2;
  logic [PW-F-1:0]      shx, shy;

  assign shx = px2[PW-1:F];
  assign shy = py2[PW-1:F];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= rcp_in.vld;
      v2   <= v1;
      done <= v2;
    end
    rx1 <= rcp_in.rx;
    ry1 <= rcp_in.ry;
    dx1 <= pick_delta(rcp_in.rx, rcp_in.ry, rcp_in.qx);
    dy1 <= pick_delta(rcp_in.ry, rcp_in.rx, rcp_in.qy);
    fx1 <= side_frac(pos_x, rcp_in.rx[RW-1]);
    fy1 <= side_frac(pos_y, rcp_in.ry[RW-1]);
    rx2 <= rx1;
    ry2 <= ry1;
    dx2 <= dx1;
    dy2 <= dy1;
    px2 <= PW'(fx1) * PW'(dx1);
    py2 <= PW'(fy1) * PW'(dy1);
    cell_x     <= pos_x[F +: rcs_pkg::CELL_W];
    cell_y     <= pos_y[F +: rcs_pkg::CELL_W];
    step_x_neg <= rx2[RW-1];
    step_y_neg <= ry2[RW-1];
    ray_x      <= rx2;
    ray_y      <= ry2;
    delta_x    <= dx2;
    delta_y    <= dy2;
    side_x     <= (shx[PW-F-1:DW] != '0) ? '1 : shx[DW-1:0];
    side_y     <= (shy[PW-F-1:DW] != '0) ? '1 : shy[DW-1:0];
  end

endmodule

[hw/rtl/raycast_column_setup_top.sv]
// ----------------------------------------------------------------------------
// raycast_column_setup_top
// Per-column ray setup of a grid raycaster: camera coordinate, ray, map cell,
// step signs, delta and initial side distances, 16.16 fixed point.
// ----------------------------------------------------------------------------
//
//  channel   ports                                  transaction at
//  -------   -------------------------------------  ---------------------
//  input     start, busy, column                    start & !busy
//  result    done, cell_*, step_*_neg, ray_*,       done (one cycle)
//            delta_*, side_*
//  config    cfg_we, cfg_index, cfg_data            cfg_we
//
//  One column enters per cycle; busy is always low. Columns pass through
//  the camera coordinate, the ray, the restoring reciprocal (one quotient
//  bit per stage) and the side distance stages, in that order.
//  Synchronous reset clears the valid bits and loads the register defaults.
//  Results cannot be held off, so nothing in the pipe ever stalls.
//
module raycast_column_setup_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [rcs_pkg::COL_W-1:0]         column,
  input  logic                              cfg_we,
  input  logic [rcs_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rcs_pkg::CFG_W-1:0]         cfg_data,
  output logic                              done,
  output logic [rcs_pkg::CELL_W-1:0]        cell_x,
  output logic [rcs_pkg::CELL_W-1:0]        cell_y,
  output logic                              step_x_neg,
  output logic                              step_y_neg,
  output logic signed [rcs_pkg::RAY_W-1:0]  ray_x,
  output logic signed [rcs_pkg::RAY_W-1:0]  ray_y,
  output logic [rcs_pkg::DIST_W-1:0]        delta_x,
  output logic [rcs_pkg::DIST_W-1:0]        delta_y,
  output logic [rcs_pkg::DIST_W-1:0]        side_x,
  output logic [rcs_pkg::DIST_W-1:0]        side_y
);

  localparam int DW = rcs_pkg::DIR_W;

  logic [rcs_pkg::POS_W-1:0] pos_x, pos_y;
  logic signed [DW-1:0]      dir_x, dir_y, plane_x, plane_y;

  rcs_pkg::cam_t   cam_s;
  rcs_pkg::ray_t   ray_s;
  rcs_pkg::recip_t rcp_s;

  // fully pipelined, never refuses a column
  assign busy = 1'b0;

  // config registers; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      dir_x   <= DW'(65536);
      dir_y   <= '0;
      plane_x <= '0;
      plane_y <= DW'(43254);
    end else if (cfg_we) begin
      case (cfg_index)
        rcs_pkg::REG_POS_X:   pos_x   <= cfg_data;
        rcs_pkg::REG_POS_Y:   pos_y   <= cfg_data;
        rcs_pkg::REG_DIR_X:   dir_x   <= cfg_data[DW-1:0];
        rcs_pkg::REG_DIR_Y:   dir_y   <= cfg_data[DW-1:0];
        rcs_pkg::REG_PLANE_X: plane_x <= cfg_data[DW-1:0];
        rcs_pkg::REG_PLANE_Y: plane_y <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  rcs_cam u_cam (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (start & ~busy),
    .column  (column),
    .cam_out (cam_s)
  );

  rcs_ray u_ray (
    .clk     (clk),
    .rst     (rst),
    .cam_in  (cam_s),
    .dir_x   (dir_x),
    .dir_y   (dir_y),
    .plane_x (plane_x),
    .plane_y (plane_y),
    .ray_out (ray_s)
  );

  rcs_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .ray_in  (ray_s),
    .rcp_out (rcp_s)
  );

  // position must be held static by the user while columns are in flight (not enforced here); read directly
  rcs_side u_side (
    .clk        (clk),
    .rst        (rst),
    .rcp_in     (rcp_s),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .done       (done),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .step_x_neg (step_x_neg),
    .step_y_neg (step_y_neg),
    .ray_x      (ray_x),
    .ray_y      (ray_y),
    .delta_x    (delta_x),
    .delta_y    (delta_y),
    .side_x     (side_x),
    .side_y     (side_y)
  );

endmodule
